[design/pws_pkg.sv]
// ----------------------------------------------------------------------------
// Waveform shaper package
// Shape codes, work class codes, default sizes and the table builders.
// ----------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

  localparam int PWS_PHASE_BITS = 16;
  localparam int PWS_SAMPLE_BITS = 16;
  localparam int PWS_TABLE_ADDR_BITS = 10;

  localparam logic [3:0] SHAPE_SAW = 4'd0;
  localparam logic [3:0] SHAPE_SINE = 4'd1;
  localparam logic [3:0] SHAPE_SQUARE = 4'd2;
  localparam logic [3:0] SHAPE_PULSE = 4'd3;
  localparam logic [3:0] SHAPE_TRIANGLE = 4'd4;
  localparam logic [3:0] SHAPE_SQUARED = 4'd5;
  localparam logic [3:0] SHAPE_INV_SQUARED = 4'd6;
  localparam logic [3:0] SHAPE_EXP = 4'd7;
  localparam logic [3:0] SHAPE_SQRT = 4'd8;
  localparam logic [3:0] SHAPE_PLUS_ONE = 4'd9;
  localparam logic [3:0] SHAPE_ZERO = 4'd10;
  localparam logic [3:0] SHAPE_MINUS_ONE = 4'd11;

  localparam logic [15:0] PULSE_WIDTH_RESET = 16'h8000;

  typedef enum logic [2:0] {
    KIND_DIRECT = 3'd0,
    KIND_SINE   = 3'd1,
    KIND_EXP    = 3'd2,
    KIND_SQUARE = 3'd3,
    KIND_SQRT   = 3'd4
  } kind_e;

  localparam longint unsigned Q_ONE = 64'd1 << 30;
  localparam longint unsigned Q_HALF = 64'd1 << 29;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  function automatic longint unsigned sin_q30(input longint unsigned theta);
    longint unsigned t2;
    longint unsigned c;
    t2 = (theta * theta) >> 30;
    c = Q_ONE;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd156;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd110;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd72;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd42;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd20;
    c = Q_ONE - ((t2 * c) >> 30) / 64'd6;
    return (theta * c) >> 30;
  endfunction

  function automatic longint unsigned exp_q30(input longint unsigned x);
    longint unsigned a;
    a = Q_ONE;
    a = Q_ONE + ((x * a) >> 30) / 64'd15;
    a = Q_ONE + ((x * a) >> 30) / 64'd14;
    a = Q_ONE + ((x * a) >> 30) / 64'd13;
    a = Q_ONE + ((x * a) >> 30) / 64'd12;
    a = Q_ONE + ((x * a) >> 30) / 64'd11;
    a = Q_ONE + ((x * a) >> 30) / 64'd10;
    a = Q_ONE + ((x * a) >> 30) / 64'd9;
    a = Q_ONE + ((x * a) >> 30) / 64'd8;
    a = Q_ONE + ((x * a) >> 30) / 64'd7;
    a = Q_ONE + ((x * a) >> 30) / 64'd6;
    a = Q_ONE + ((x * a) >> 30) / 64'd5;
    a = Q_ONE + ((x * a) >> 30) / 64'd4;
    a = Q_ONE + ((x * a) >> 30) / 64'd3;
    a = Q_ONE + ((x * a) >> 30) / 64'd2;
    a = Q_ONE + ((x * a) >> 30);
    return a;
  endfunction

  localparam longint unsigned EXP_SPAN = exp_q30(Q_ONE) - Q_ONE;

  function automatic longint sine_entry(input int k, input int tab_bits, input int s_bits);
    longint unsigned n4;
    longint unsigned q;
    longint unsigned r;
    longint unsigned m;
    longint unsigned th;
    longint mag;
    n4 = 64'd1 << (tab_bits - 2);
    q = longint'(k) >> (tab_bits - 2);
    r = longint'(k) & (n4 - 64'd1);
    m = q[0] ? n4 - r : r;
    th = (HALF_PI_Q30 * m) >> (tab_bits - 2);
    mag = longint'((sin_q30(th) * (64'd1 << (s_bits - 1)) + Q_HALF) >> 30);
    if (mag > (longint'(1) << (s_bits - 1)) - 1) begin
      mag = (longint'(1) << (s_bits - 1)) - 1;
    end
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic longint exp_entry(input int k, input int tab_bits, input int s_bits);
    longint unsigned x;
    longint unsigned y;
    longint v;
    longint h;
    x = longint'(k) << (30 - tab_bits);
    y = ((exp_q30(x) - Q_ONE) << 30) / EXP_SPAN;
    h = longint'(1) << (s_bits - 1);
    v = longint'(((y << s_bits) + Q_HALF) >> 30) - h;
    if (v < -h) begin
      v = -h;
    end
    if (v > h - 1) begin
      v = h - 1;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[design/periodic_waveform_shaper_unit.sv]
// ----------------------------------------------------------------------------
// Periodic waveform shaper
// Maps a phase fraction to one sample of the configured periodic waveform.
// ----------------------------------------------------------------------------
// A phase beat is taken at a clock edge with start high and busy low; phase_i
// is an unsigned fraction of the period. Each beat yields exactly one sample
// on sample_o, marked by sample_valid_o for one cycle. One beat can be taken
// every cycle while busy is low, and results leave in order at the same rate.
// The square-root pipeline resolves one result bit per stage; every shape
// travels through it to keep the order.
// The receiver cannot stall: each sample is shown for one cycle only.
// The shape and pulse width registers sit on the APB port at byte addresses
// 0 and 4; they must be written only while no beat is in flight, which the
// block itself does not enforce. Reset clears all pipeline valids, sets the
// shape to sawtooth and the pulse width to one half.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_waveform_shaper_unit #(
  parameter int PHASE_BITS = pws_pkg::PWS_PHASE_BITS,
  parameter int SAMPLE_BITS = pws_pkg::PWS_SAMPLE_BITS,
  parameter int TABLE_ADDR_BITS = pws_pkg::PWS_TABLE_ADDR_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [PHASE_BITS-1:0]  phase_i,
  output logic                        sample_valid_o,
  output logic [SAMPLE_BITS-1:0]      sample_o
);
  import pws_pkg::*;

  localparam int ITEM_W = 3 + PHASE_BITS + SAMPLE_BITS;

  logic [3:0]        shape_q;
  logic [15:0]       pulse_width_q;
  logic              cfg_write;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic [ITEM_W-1:0] fr_item;
  logic [ITEM_W-1:0] q_item;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata = paddr[2] ? {16'h0000, pulse_width_q} : {28'h0000000, shape_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_SAW;
      pulse_width_q <= PULSE_WIDTH_RESET;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        pulse_width_q <= pwdata[15:0];
      end else begin
        shape_q <= pwdata[3:0];
      end
    end
  end

  pws_front #(
    .PHASE_BITS(PHASE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .ITEM_W(ITEM_W)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .phase_i(phase_i),
    .shape_i(shape_q),
    .pulse_width_i(pulse_width_q),
    .q_full_i(q_full),
    .busy_o(busy),
    .push_o(push),
    .item_o(fr_item)
  );

  pws_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(fr_item),
    .pop_i(~q_empty),
    .full_o(q_full),
    .empty_o(q_empty),
    .data_o(q_item)
  );

  pws_back #(
    .PHASE_BITS(PHASE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .ITEM_W(ITEM_W)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(~q_empty),
    .item_i(q_item),
    .valid_o(sample_valid_o),
    .sample_o(sample_o)
  );

endmodule

`default_nettype wire

[design/pws_front.sv]
// ----------------------------------------------------------------------------
// Waveform shaper front end
// Accepts phase beats, computes the simple shapes and classifies the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_front #(
  parameter int PHASE_BITS = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int ITEM_W = 3 + PHASE_BITS + SAMPLE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [PHASE_BITS-1:0] phase_i,
  input  wire logic [3:0]            shape_i,
  input  wire logic [15:0]           pulse_width_i,
  input  wire logic                  q_full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output logic [ITEM_W-1:0]          item_o
);
  import pws_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int SB = SAMPLE_BITS;

  typedef struct packed {
    kind_e           kind;
    logic [PB-1:0]   opnd;
    logic [SB-1:0]   val;
  } item_t;

  localparam logic [SB-1:0] MAXV = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] MINV = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB+1:0] HALF_W = (SB+2)'(1) << (SB-1);
  localparam logic [SB+1:0] THREE_H = (SB+2)'(3) << (SB-1);

  logic          fr_valid_q;
  item_t         fr_item_q;
  item_t         item_d;
  logic          accept;
  logic [PB+SB-1:0] saw_ext;
  logic [PB+SB:0]   tri_ext;
  logic [SB-1:0]    saw_v;
  logic [SB:0]      tri_t;
  logic [SB+1:0]    tri_d;
  logic [SB-1:0]    tri_v;
  logic             pulse_low;

  assign busy_o = fr_valid_q & q_full_i;
  assign push_o = fr_valid_q & ~q_full_i;
  assign item_o = fr_item_q;
  assign accept = start_i & ~busy_o;

  assign saw_ext = {phase_i, {SB{1'b0}}} >> PB;
  assign saw_v = {~saw_ext[SB-1], saw_ext[SB-2:0]};
  assign tri_ext = {phase_i, {(SB+1){1'b0}}} >> PB;
  assign tri_t = tri_ext[SB:0];
  assign tri_d = THREE_H - {1'b0, tri_t};
  assign pulse_low = {phase_i, 16'h0000} < {pulse_width_i, {PB{1'b0}}};

  always_comb begin
    if (!phase_i[PB-1]) begin
      tri_v = {~tri_t[SB-1], tri_t[SB-2:0]};
    end else if (tri_d == HALF_W) begin
      tri_v = MAXV;
    end else begin
      tri_v = tri_d[SB-1:0];
    end
  end

  always_comb begin
    item_d.kind = KIND_DIRECT;
    item_d.opnd = phase_i;
    item_d.val = '0;
    case (shape_i)
      SHAPE_SAW: item_d.val = saw_v;
      SHAPE_SINE: item_d.kind = KIND_SINE;
      SHAPE_SQUARE: item_d.val = phase_i[PB-1] ? MAXV : MINV;
      SHAPE_PULSE: item_d.val = pulse_low ? MINV : MAXV;
      SHAPE_TRIANGLE: item_d.val = tri_v;
      SHAPE_SQUARED: item_d.kind = KIND_SQUARE;
      SHAPE_INV_SQUARED: begin
        if (phase_i == '0) begin
          item_d.val = MAXV;
        end else begin
          item_d.kind = KIND_SQUARE;
          item_d.opnd = ~phase_i + PB'(1);
        end
      end
      SHAPE_EXP: item_d.kind = KIND_EXP;
      SHAPE_SQRT: item_d.kind = KIND_SQRT;
      SHAPE_PLUS_ONE: item_d.val = MAXV;
      SHAPE_MINUS_ONE: item_d.val = MINV;
      default: item_d.val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (accept) begin
      fr_valid_q <= 1'b1;
    end else if (push_o) begin
      fr_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[design/pws_queue.sv]
// ----------------------------------------------------------------------------
// Waveform shaper queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_queue #(
  parameter int WIDTH = 35
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/pws_back.sv]
// ----------------------------------------------------------------------------
// Waveform shaper back end
// Table lookup, squaring and a pipelined square root, one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_back #(
  parameter int PHASE_BITS = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int ITEM_W = 3 + PHASE_BITS + SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [ITEM_W-1:0]      item_i,
  output logic                        valid_o,
  output logic [SAMPLE_BITS-1:0]      sample_o
);
  import pws_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int TB = TABLE_ADDR_BITS;
  localparam int N = 1 << TB;

  typedef struct packed {
    kind_e           kind;
    logic [PB-1:0]   opnd;
    logic [SB-1:0]   val;
  } item_t;

  item_t            item;
  logic [SB-1:0]    sine_rom [N];
  logic [SB-1:0]    exp_rom [N];
  logic [PB+TB-1:0] idx_ext;
  logic [TB-1:0]    idx;
  logic [PB+2*SB-1:0] rad_ext;
  logic [SB-1:0]    val1;

  logic             s1_valid_q;
  kind_e            s1_kind_q;
  logic [SB-1:0]    s1_val_q;
  logic [2*PB-1:0]  s1_prod_q;
  logic [2*SB-1:0]  s1_rad_q;
  logic [2*PB+SB-1:0] sq_ext;

  logic             st_valid_q [SB];
  kind_e            st_kind_q [SB];
  logic [SB-1:0]    st_val_q [SB];
  logic [SB+1:0]    st_rem_q [SB];
  logic [SB-1:0]    st_root_q [SB];
  logic [2*SB-1:0]  st_rad_q [SB];

  logic             in_valid [SB];
  kind_e            in_kind [SB];
  logic [SB-1:0]    in_val [SB];
  logic [SB+1:0]    in_rem [SB];
  logic [SB-1:0]    in_root [SB];
  logic [2*SB-1:0]  in_rad [SB];

  logic             out_valid_q;
  logic [SB-1:0]    sample_q;
  logic [SB-1:0]    root_last;

  assign item = item_t'(item_i);

  for (genvar k = 0; k < N; k++) begin : g_rom
    localparam logic [SB-1:0] SINE_V = SB'(sine_entry(k, TB, SB));
    localparam logic [SB-1:0] EXP_V = SB'(exp_entry(k, TB, SB));
    assign sine_rom[k] = SINE_V;
    assign exp_rom[k] = EXP_V;
  end

  assign idx_ext = {item.opnd, {TB{1'b0}}} >> PB;
  assign idx = idx_ext[TB-1:0];
  assign rad_ext = {item.opnd, {(2*SB){1'b0}}} >> PB;

  always_comb begin
    case (item.kind)
      KIND_SINE: val1 = sine_rom[idx];
      KIND_EXP: val1 = exp_rom[idx];
      default: val1 = item.val;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= item.kind;
    s1_val_q <= val1;
    s1_prod_q <= {{PB{1'b0}}, item.opnd} * {{PB{1'b0}}, item.opnd};
    s1_rad_q <= rad_ext[2*SB-1:0];
  end

  assign sq_ext = {s1_prod_q, {SB{1'b0}}} >> (2 * PB);

  for (genvar j = 0; j < SB; j++) begin : g_sqrt
    logic [SB+1:0] rem_sh;
    logic [SB+1:0] trial;
    logic          take;

    if (j == 0) begin : g_first
      assign in_valid[j] = s1_valid_q;
      assign in_kind[j] = s1_kind_q;
      assign in_val[j] = (s1_kind_q == KIND_SQUARE) ?
                         {~sq_ext[SB-1], sq_ext[SB-2:0]} : s1_val_q;
      assign in_rem[j] = '0;
      assign in_root[j] = '0;
      assign in_rad[j] = s1_rad_q;
    end else begin : g_next
      assign in_valid[j] = st_valid_q[j-1];
      assign in_kind[j] = st_kind_q[j-1];
      assign in_val[j] = st_val_q[j-1];
      assign in_rem[j] = st_rem_q[j-1];
      assign in_root[j] = st_root_q[j-1];
      assign in_rad[j] = st_rad_q[j-1];
    end

    assign rem_sh = {in_rem[j][SB-1:0], in_rad[j][2*SB-1 -: 2]};
    assign trial = {in_root[j], 2'b01};
    assign take = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[j] <= 1'b0;
      end else begin
        st_valid_q[j] <= in_valid[j];
      end
    end

    always_ff @(posedge clk_i) begin
      st_kind_q[j] <= in_kind[j];
      st_val_q[j] <= in_val[j];
      st_rem_q[j] <= take ? rem_sh - trial : rem_sh;
      st_root_q[j] <= {in_root[j][SB-2:0], take};
      st_rad_q[j] <= {in_rad[j][2*SB-3:0], 2'b00};
    end
  end

  assign root_last = st_root_q[SB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= st_valid_q[SB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_kind_q[SB-1] == KIND_SQRT) begin
      sample_q <= {~root_last[SB-1], root_last[SB-2:0]};
    end else begin
      sample_q <= st_val_q[SB-1];
    end
  end

  assign valid_o = out_valid_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

[design/pws_checker.sv]
// ----------------------------------------------------------------------------
// Waveform shaper checker
// Port-level properties of the shaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_checker #(
  parameter int PHASE_BITS = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int TABLE_ADDR_BITS = 10
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   psel,
  input wire logic                   penable,
  input wire logic                   pwrite,
  input wire logic [2:0]             paddr,
  input wire logic [31:0]            pwdata,
  input wire logic [31:0]            prdata,
  input wire logic                   pready,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [PHASE_BITS-1:0]  phase_i,
  input wire logic                   sample_valid_o,
  input wire logic [SAMPLE_BITS-1:0] sample_o
);

  localparam int LAT = SAMPLE_BITS + 4;
  localparam int TAB_N = 1 << TABLE_ADDR_BITS;

  logic unused_ok;
  assign unused_ok = ^{phase_i, sample_o, TAB_N[0]};

  a_beat_yields_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT sample_valid_o)
    else $error("accepted beat gave no sample");

  a_no_phantom_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(start && !busy, LAT))
    else $error("sample without an accepted beat");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("queue backed up");

  a_shape_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) |=>
    (paddr[2] || prdata[3:0] == $past(pwdata[3:0])))
    else $error("shape register readback mismatch");

endmodule

bind periodic_waveform_shaper_unit pws_checker #(
  .PHASE_BITS(PHASE_BITS),
  .SAMPLE_BITS(SAMPLE_BITS),
  .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
) u_pws_checker (.*);

`default_nettype wire
